### hw/rtl/stereo_tremolo_gain_defines.svh
// assertion macros for the tremolo gain rtl
// no dependencies; taken in by files that carry assertions
`ifndef STEREO_TREMOLO_GAIN_DEFINES_SVH
`define STEREO_TREMOLO_GAIN_DEFINES_SVH

// same-cycle implication, off during reset
`define STG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stg assertion failed");

// next-cycle implication, off during reset
`define STG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stg assertion failed");

`endif

### hw/rtl/stg_pkg.sv
// shared constants and types for the stereo tremolo gain block
// no dependencies
`default_nettype none

package stg_pkg;

  // envelope table size and derived widths
  localparam int TABLE_STEPS = 1024;
  localparam int IDX_BITS    = $clog2(TABLE_STEPS);
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_BITS  = IDX_BITS + FRAC_BITS;
  localparam int STEP_BITS   = 27;
  localparam int SAMPLE_BITS = 24;
  localparam int PROD_BITS   = SAMPLE_BITS + IDX_BITS + 1;
  localparam int CFG_IDX_BITS = 3;

  // phase limits
  localparam logic [STEP_BITS:0] PHASE_TOP =
    (STEP_BITS + 1)'(TABLE_STEPS) << FRAC_BITS;
  localparam logic [PHASE_BITS-1:0] PHASE_CLAMP =
    PHASE_BITS'(TABLE_STEPS - 1) << FRAC_BITS;

  // step register reset value (unity step in Q10.16 times 1024)
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(67108864);

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEFT_RISE  = 3'd0,
    CFG_LEFT_FALL  = 3'd1,
    CFG_RIGHT_RISE = 3'd2,
    CFG_RIGHT_FALL = 3'd3,
    CFG_STEREO     = 3'd4
  } cfg_idx_t;

  // rise and fall steps of one modulator
  typedef struct packed {
    logic [STEP_BITS-1:0] rise;
    logic [STEP_BITS-1:0] fall;
  } step_pair_t;

endpackage

`default_nettype wire

### hw/rtl/stereo_tremolo_gain.sv
// top level of the stereo tremolo gain block
// depends on stg_pkg, stg_lfo and stg_gain
`default_nettype none

// Triangle-envelope tremolo on a stream of signed 24-bit samples. Each input
// beat advances the left modulator, or the right one for an odd channel when
// stereo is on, and the sample is scaled by the new phase integer part over
// 1024 (floor). One beat is accepted every cycle while in_stall is low. The
// phase update and the input register load happen at the accepting edge, and
// the multiply lands in the output register when that register takes the beat
// from the input register. The phase add, compare and clamp of one modulator
// close the only loop and set the single-cycle rate. Step and stereo registers
// are to be written by the user only while idle; the block does not enforce it.
module stereo_tremolo_gain (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [stg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [stg_pkg::STEP_BITS-1:0]         cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_in,
  input  wire logic                                  channel_odd,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [stg_pkg::SAMPLE_BITS-1:0]     sample_out
);

  stg_pkg::step_pair_t left_steps;
  stg_pkg::step_pair_t right_steps;
  logic                stereo_enable;

  logic                                 in_accept;
  logic                                 use_right;
  logic [stg_pkg::IDX_BITS-1:0]         left_idx;
  logic [stg_pkg::IDX_BITS-1:0]         right_idx;
  logic                                 a_valid;
  logic                                 a_take;
  logic signed [stg_pkg::SAMPLE_BITS-1:0] a_sample;
  logic [stg_pkg::IDX_BITS-1:0]         a_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_steps    <= '{rise: stg_pkg::STEP_RESET, fall: stg_pkg::STEP_RESET};
      right_steps   <= '{rise: stg_pkg::STEP_RESET, fall: stg_pkg::STEP_RESET};
      stereo_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (stg_pkg::cfg_idx_t'(cfg_index))
        stg_pkg::CFG_LEFT_RISE:  left_steps.rise  <= cfg_data;
        stg_pkg::CFG_LEFT_FALL:  left_steps.fall  <= cfg_data;
        stg_pkg::CFG_RIGHT_RISE: right_steps.rise <= cfg_data;
        stg_pkg::CFG_RIGHT_FALL: right_steps.fall <= cfg_data;
        stg_pkg::CFG_STEREO:     stereo_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input handshake and channel routing
  assign in_stall  = a_valid && !a_take;
  assign in_accept = in_valid && !in_stall;
  assign use_right = stereo_enable && channel_odd;

  // modulators
  stg_lfo u_left_lfo (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept && !use_right),
    .steps   (left_steps),
    .idx     (left_idx)
  );

  stg_lfo u_right_lfo (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept && use_right),
    .steps   (right_steps),
    .idx     (right_idx)
  );

  // input register: sample and its gain index
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_valid || a_take) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_sample <= sample_in;
      a_idx    <= use_right ? right_idx : left_idx;
    end
  end

  // multiply and output register
  stg_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_sample   (a_sample),
    .a_idx      (a_idx),
    .a_take     (a_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

### hw/rtl/stg_lfo.sv
// triangle phase accumulator for one tremolo modulator
// depends on stg_pkg and stereo_tremolo_gain_defines.svh
`default_nettype none
`include "stereo_tremolo_gain_defines.svh"

module stg_lfo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire stg_pkg::step_pair_t           steps,
  output logic [stg_pkg::IDX_BITS-1:0]       idx
);

  logic [stg_pkg::PHASE_BITS-1:0] phase;
  logic [stg_pkg::PHASE_BITS-1:0] phase_next;
  logic                           falling;
  logic                           falling_next;
  logic [stg_pkg::STEP_BITS:0]    rise_sum;
  logic [stg_pkg::STEP_BITS-1:0]  phase_wide;

  // next phase and direction
  always_comb begin
    phase_wide   = stg_pkg::STEP_BITS'(phase);
    rise_sum     = (stg_pkg::STEP_BITS + 1)'(phase) + (stg_pkg::STEP_BITS + 1)'(steps.rise);
    phase_next   = phase;
    falling_next = falling;
    if (!falling) begin
      if (rise_sum >= stg_pkg::PHASE_TOP) begin
        phase_next   = stg_pkg::PHASE_CLAMP;
        falling_next = 1'b1;
      end else begin
        phase_next = rise_sum[stg_pkg::PHASE_BITS-1:0];
      end
    end else begin
      if (phase_wide <= steps.fall) begin
        phase_next   = '0;
        falling_next = 1'b0;
      end else begin
        phase_next = stg_pkg::PHASE_BITS'(phase_wide - steps.fall);
      end
    end
  end

  // gain index after this beat's update
  assign idx = phase_next[stg_pkg::PHASE_BITS-1:stg_pkg::FRAC_BITS];

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      falling <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      falling <= falling_next;
    end
  end

  // checks
  `STG_ASSERT_NEXT(a_lfo_hold, clk, rst, !advance,
                   phase == $past(phase) && falling == $past(falling))
  `STG_ASSERT_NOW(a_lfo_turn_down, clk, rst, $rose(falling),
                  phase == stg_pkg::PHASE_CLAMP)
  `STG_ASSERT_NOW(a_lfo_turn_up, clk, rst, $fell(falling), phase == '0)

endmodule

`default_nettype wire

### hw/rtl/stg_gain.sv
// gain multiply and output register of the tremolo block
// depends on stg_pkg
`default_nettype none

module stg_gain (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                a_valid,
  input  wire logic signed [stg_pkg::SAMPLE_BITS-1:0] a_sample,
  input  wire logic [stg_pkg::IDX_BITS-1:0]        a_idx,
  output logic                                     a_take,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [stg_pkg::SAMPLE_BITS-1:0]   sample_out
);

  logic signed [stg_pkg::PROD_BITS-1:0] prod;
  logic signed [stg_pkg::PROD_BITS-1:0] scaled;

  // signed sample times unsigned index, floor divide by table size
  always_comb begin
    prod   = stg_pkg::PROD_BITS'(a_sample) * $signed({1'b0, a_idx});
    scaled = prod >>> stg_pkg::IDX_BITS;
  end

  // output register takes a beat when empty or drained
  assign a_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_take) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && a_valid) begin
      sample_out <= scaled[stg_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### dv/tb_stereo_tremolo_gain.sv
// self-checking testbench for stereo_tremolo_gain: directed and random sample beats
// depends on stg_pkg and the stereo_tremolo_gain rtl only
`default_nettype none

module tb_stereo_tremolo_gain;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [stg_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
    {1'b0, {(stg_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [stg_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(stg_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam logic [stg_pkg::STEP_BITS-1:0] STEP_MAX    = '1;
  localparam int                            IDLE_LIMIT  = 4000;
  localparam int                            PHASE_BEATS = 70;

  // predicted gain envelope per modulator and the queue of expected samples
  class tremolo_scoreboard;
    logic [stg_pkg::STEP_BITS-1:0]          rise_step[2];
    logic [stg_pkg::STEP_BITS-1:0]          fall_step[2];
    logic [stg_pkg::PHASE_BITS-1:0]         phase[2];
    bit                                     falling[2];
    bit                                     stereo;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] expected_q[$];
    int                                     errors;

    function new();
      for (int i = 0; i < 2; i++) begin
        rise_step[i] = stg_pkg::STEP_RESET;
        fall_step[i] = stg_pkg::STEP_RESET;
        phase[i]     = '0;
        falling[i]   = 1'b0;
      end
      stereo = 1'b0;
      errors = 0;
    endfunction

    // register mirror; unknown indexes fall through
    function void write_reg(logic [stg_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [stg_pkg::STEP_BITS-1:0] data);
      case (idx)
        stg_pkg::CFG_LEFT_RISE:  rise_step[0] = data;
        stg_pkg::CFG_LEFT_FALL:  fall_step[0] = data;
        stg_pkg::CFG_RIGHT_RISE: rise_step[1] = data;
        stg_pkg::CFG_RIGHT_FALL: fall_step[1] = data;
        stg_pkg::CFG_STEREO:     stereo = data[0];
        default: ;
      endcase
    endfunction

    // advance the selected modulator and queue the scaled sample
    function void note_input(logic signed [stg_pkg::SAMPLE_BITS-1:0] s, logic odd);
      int                             side;
      logic [stg_pkg::STEP_BITS:0]    sum;
      logic [stg_pkg::IDX_BITS-1:0]   gain;
      longint                         prod;
      side = (stereo && odd) ? 1 : 0;
      if (!falling[side]) begin
        sum = (stg_pkg::STEP_BITS+1)'(phase[side]) +
              (stg_pkg::STEP_BITS+1)'(rise_step[side]);
        if (sum >= stg_pkg::PHASE_TOP) begin
          phase[side]   = stg_pkg::PHASE_CLAMP;
          falling[side] = 1'b1;
        end else begin
          phase[side] = stg_pkg::PHASE_BITS'(sum);
        end
      end else if (stg_pkg::STEP_BITS'(phase[side]) <= fall_step[side]) begin
        phase[side]   = '0;
        falling[side] = 1'b0;
      end else begin
        phase[side] = phase[side] - stg_pkg::PHASE_BITS'(fall_step[side]);
      end
      gain = phase[side][stg_pkg::PHASE_BITS-1 -: stg_pkg::IDX_BITS];
      // floor division by the table size is an arithmetic shift
      prod = longint'(s) * longint'(gain);
      expected_q.push_back(stg_pkg::SAMPLE_BITS'(prod >>> stg_pkg::IDX_BITS));
    endfunction

    function void check_result(logic signed [stg_pkg::SAMPLE_BITS-1:0] got);
      logic signed [stg_pkg::SAMPLE_BITS-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected sample_out beat: expected none actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch: expected %0d actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_write;
  logic [stg_pkg::CFG_IDX_BITS-1:0]       cfg_index;
  logic [stg_pkg::STEP_BITS-1:0]          cfg_data;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   channel_odd;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_out;

  bit                                     quiet;
  tremolo_scoreboard                      sb = new();

  stereo_tremolo_gain u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .channel_odd (channel_odd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitors on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(sample_in, channel_odd);
    if (!rst && out_valid && !out_stall) sb.check_result(sample_out);
  end

  // output backpressure in random bursts, off in the quiet tail
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [stg_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return stg_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly slow steps so the triangle is swept, some extremes
  function automatic logic [stg_pkg::STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STEP_MAX;
      2:       return stg_pkg::STEP_RESET;
      3, 4:    return stg_pkg::STEP_BITS'($urandom);
      default: return stg_pkg::STEP_BITS'($urandom_range(1 << 12, 48 << stg_pkg::FRAC_BITS));
    endcase
  endfunction

  // one register write; the write enable drops on the following cycle
  task automatic set_reg(input logic [stg_pkg::CFG_IDX_BITS-1:0] idx,
                         input logic [stg_pkg::STEP_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_all(input logic [stg_pkg::STEP_BITS-1:0] lr,
                          input logic [stg_pkg::STEP_BITS-1:0] lf,
                          input logic [stg_pkg::STEP_BITS-1:0] rr,
                          input logic [stg_pkg::STEP_BITS-1:0] rf,
                          input logic [stg_pkg::STEP_BITS-1:0] st);
    set_reg(stg_pkg::CFG_LEFT_RISE, lr);
    set_reg(stg_pkg::CFG_LEFT_FALL, lf);
    set_reg(stg_pkg::CFG_RIGHT_RISE, rr);
    set_reg(stg_pkg::CFG_RIGHT_FALL, rf);
    set_reg(stg_pkg::CFG_STEREO, st);
  endtask

  // one input beat, with an optional gap ahead of it
  task automatic send_sample(input logic signed [stg_pkg::SAMPLE_BITS-1:0] s,
                             input logic odd);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= s;
    channel_odd <= odd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // main sequence
  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    sample_in   = '0;
    channel_odd = 1'b0;
    quiet       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset steps: left gain swings between top entry and zero, mono routing
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('1, 1'b0);
    send_sample(stg_pkg::SAMPLE_BITS'(1), 1'b1);

    // writes to indexes past the register list change nothing
    drain();
    for (int k = int'(stg_pkg::CFG_STEREO) + 1; k < (1 << stg_pkg::CFG_IDX_BITS); k++)
      set_reg(stg_pkg::CFG_IDX_BITS'(k), STEP_MAX);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);

    // stereo on: odd beats move to the right modulator
    drain();
    set_reg(stg_pkg::CFG_STEREO, STEP_MAX);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);

    // zero rise step parks the left modulator at zero
    drain();
    set_reg(stg_pkg::CFG_LEFT_RISE, '0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);

    // oversized rise and zero fall hold the right modulator at the top entry
    drain();
    set_reg(stg_pkg::CFG_RIGHT_RISE, STEP_MAX);
    set_reg(stg_pkg::CFG_RIGHT_FALL, '0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 7) quiet = 1'b1;
      case (ph)
        0: load_all(stg_pkg::STEP_BITS'($urandom_range(1 << 14, 40 << stg_pkg::FRAC_BITS)),
                    stg_pkg::STEP_BITS'($urandom_range(1 << 14, 40 << stg_pkg::FRAC_BITS)),
                    stg_pkg::STEP_BITS'($urandom_range(1 << 14, 40 << stg_pkg::FRAC_BITS)),
                    stg_pkg::STEP_BITS'($urandom_range(1 << 14, 40 << stg_pkg::FRAC_BITS)),
                    stg_pkg::STEP_BITS'(1));
        1: load_all(stg_pkg::STEP_RESET, '0, pick_step(), pick_step(), '0);
        2: load_all(STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX);
        3: load_all('0, '0, '0, '0, stg_pkg::STEP_BITS'(1));
        default: load_all(pick_step(), pick_step(), pick_step(), pick_step(),
                          stg_pkg::STEP_BITS'($urandom));
      endcase
      repeat (PHASE_BEATS) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
    end

    // wrap up
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
